[src/mbrir_pkg.sv]
package mbrir_pkg;

    localparam int MAX_REGS_DEF = 16;

    localparam logic [1:0] FUNC_REQ  = 2'd0;
    localparam logic [1:0] FUNC_BYTE = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_RESP = 2'd1;
    localparam logic [1:0] STAT_SHORT   = 2'd2;
    localparam logic [1:0] STAT_BAD     = 2'd3;

    localparam logic [1:0] CFG_RESP_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_TAIL_TIMEOUT = 2'd1;

    localparam logic [15:0] RESP_TIMEOUT_RST = 16'd100;
    localparam logic [15:0] TAIL_TIMEOUT_RST = 16'd10;

    localparam logic [7:0]  FUNC_CODE = 8'h04;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TX,
        ST_WAIT,
        ST_RECV,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] reg_value;
        logic [1:0]  status;
        logic [15:0] latency_ticks;
        logic        last;
    } t_rsp;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_rsp mk_tx(input logic [7:0] b);
        t_rsp r;
        r = '0;
        r.kind = KIND_TX;
        r.tx_byte = b;
        return r;
    endfunction

    function automatic t_rsp mk_word(input logic [15:0] w);
        t_rsp r;
        r = '0;
        r.kind = KIND_WORD;
        r.reg_value = w;
        return r;
    endfunction

    function automatic t_rsp mk_status(input logic [1:0] st, input logic [15:0] lat);
        t_rsp r;
        r = '0;
        r.kind = KIND_STATUS;
        r.status = st;
        r.latency_ticks = lat;
        r.last = 1'b1;
        return r;
    endfunction

endpackage

[src/mbrir_if.sv]
interface mbrir_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  device_address;
    logic [15:0] register_address;
    logic [7:0]  register_count;
    logic [7:0]  rx_byte;

    modport source (
        output valid, func, device_address, register_address, register_count, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, func, device_address, register_address, register_count, rx_byte,
        output ready
    );
endinterface

interface mbrir_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_value;
    logic [1:0]  status;
    logic [15:0] latency_ticks;
    logic        last;

    modport source (
        output valid, kind, tx_byte, reg_value, status, latency_ticks, last,
        input  ready
    );
    modport sink (
        input  valid, kind, tx_byte, reg_value, status, latency_ticks, last,
        output ready
    );
endinterface

interface mbrir_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] wr_data;

    modport source (
        output valid, reg_index, wr_data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, wr_data,
        output ready
    );
endinterface

[src/modbus_read_input_registers_master_top.sv]
// an accepted request enters the transmit state, which registers its transmit words, one word
// a cycle while the sink takes them; a byte or tick result shows in the cycle after acceptance
// on a good final byte each register word is sent after a registered memory read, then status
// throughput: one input word a cycle while no result is pending; none during a result burst
// reset: synchronous, active low; clears control state, timeouts go to 100 and 10 ticks;
// the register word memory is not cleared
module modbus_read_input_registers_master_top #(
    parameter int MAX_REGS = mbrir_pkg::MAX_REGS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbrir_req_if.sink     i_req,
    mbrir_rsp_if.source   o_rsp,
    mbrir_cfg_if.sink     i_cfg
);

    localparam int WAW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

    mbrir_pkg::t_state r_state, n_state;
    mbrir_pkg::t_rsp   r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [15:0]       r_resp_to, r_tail_to;
    logic [7:0]        r_target, n_target;
    logic [15:0]       r_reg_addr, n_reg_addr;
    logic [7:0]        r_expected, n_expected;
    logic [7:0]        r_idx, n_idx;
    logic [2:0]        r_tx_idx, n_tx_idx;
    logic [15:0]       r_crc, n_crc;
    logic              r_hdr_ok, n_hdr_ok;
    logic [7:0]        r_crc_lo, n_crc_lo;
    logic [15:0]       r_timer, n_timer;
    logic [15:0]       r_latency, n_latency;
    logic [WAW-1:0]    r_word_idx, n_word_idx;

    logic              w_in_acc;
    logic              w_out_free;
    logic [15:0]       w_timer_inc;
    logic [8:0]        w_total_m3;
    logic [7:0]        w_tx_byte;
    logic [7:0]        w_d;
    logic              w_st_en;
    logic [15:0]       w_rd_data;

    assign i_req.ready = (r_state inside {mbrir_pkg::ST_IDLE, mbrir_pkg::ST_WAIT,
                                          mbrir_pkg::ST_RECV}) && !r_out_valid;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.kind          = r_out.kind;
    assign o_rsp.tx_byte       = r_out.tx_byte;
    assign o_rsp.reg_value     = r_out.reg_value;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.latency_ticks = r_out.latency_ticks;
    assign o_rsp.last          = r_out.last;

    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_timer_inc = r_timer + 16'd1;
    assign w_total_m3  = {r_expected, 1'b0} + 9'd2;
    assign w_d         = r_idx - 8'd3;

    always_comb begin
        case (r_tx_idx)
            3'd0:    w_tx_byte = r_target;
            3'd1:    w_tx_byte = mbrir_pkg::FUNC_CODE;
            3'd2:    w_tx_byte = r_reg_addr[15:8];
            3'd3:    w_tx_byte = r_reg_addr[7:0];
            3'd4:    w_tx_byte = 8'h00;
            3'd5:    w_tx_byte = r_expected;
            3'd6:    w_tx_byte = r_crc[7:0];
            default: w_tx_byte = r_crc[15:8];
        endcase
    end

    mbrir_data_store #(
        .MAX_REGS (MAX_REGS)
    ) u_store (
        .i_clk      (i_clk),
        .i_byte_en  (w_st_en),
        .i_byte_pos (w_d[WAW:0]),
        .i_byte     (i_req.rx_byte),
        .i_rd_addr  (r_word_idx),
        .o_rd_data  (w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_target    = r_target;
        n_reg_addr  = r_reg_addr;
        n_expected  = r_expected;
        n_idx       = r_idx;
        n_tx_idx    = r_tx_idx;
        n_crc       = r_crc;
        n_hdr_ok    = r_hdr_ok;
        n_crc_lo    = r_crc_lo;
        n_timer     = r_timer;
        n_latency   = r_latency;
        n_word_idx  = r_word_idx;
        w_st_en     = 1'b0;

        case (r_state)
            mbrir_pkg::ST_IDLE: begin
                if (w_in_acc && i_req.func == mbrir_pkg::FUNC_REQ) begin
                    if ({1'b0, i_req.register_count} > 9'(MAX_REGS)) begin
                        n_out       = mbrir_pkg::mk_status(mbrir_pkg::STAT_BAD, 16'd0);
                        n_out_valid = 1'b1;
                    end else begin
                        n_target   = i_req.device_address;
                        n_reg_addr = i_req.register_address;
                        n_expected = i_req.register_count;
                        n_idx      = 8'd0;
                        n_tx_idx   = 3'd0;
                        n_crc      = mbrir_pkg::CRC_INIT;
                        n_hdr_ok   = 1'b0;
                        n_crc_lo   = 8'd0;
                        n_timer    = 16'd0;
                        n_latency  = 16'd0;
                        n_state    = mbrir_pkg::ST_TX;
                    end
                end
            end
            mbrir_pkg::ST_TX: begin
                if (w_out_free) begin
                    n_out       = mbrir_pkg::mk_tx(w_tx_byte);
                    n_out_valid = 1'b1;
                    if (r_tx_idx < 3'd6) begin
                        n_crc = mbrir_pkg::crc_add(r_crc, w_tx_byte);
                    end
                    n_tx_idx = r_tx_idx + 3'd1;
                    if (r_tx_idx == 3'd7) begin
                        n_state = mbrir_pkg::ST_WAIT;
                    end
                end
            end
            mbrir_pkg::ST_WAIT: begin
                if (w_in_acc && i_req.func == mbrir_pkg::FUNC_TICK) begin
                    n_timer = w_timer_inc;
                    if (w_timer_inc >= r_resp_to) begin
                        n_out       = mbrir_pkg::mk_status(mbrir_pkg::STAT_NO_RESP, 16'd0);
                        n_out_valid = 1'b1;
                        n_state     = mbrir_pkg::ST_IDLE;
                    end
                end else if (w_in_acc && i_req.func == mbrir_pkg::FUNC_BYTE) begin
                    n_latency = r_timer;
                    n_timer   = 16'd0;
                    n_hdr_ok  = (i_req.rx_byte == r_target);
                    n_crc     = mbrir_pkg::crc_add(mbrir_pkg::CRC_INIT, i_req.rx_byte);
                    n_idx     = 8'd1;
                    n_state   = mbrir_pkg::ST_RECV;
                end
            end
            mbrir_pkg::ST_RECV: begin
                if (w_in_acc && i_req.func == mbrir_pkg::FUNC_TICK) begin
                    n_timer = w_timer_inc;
                    if (w_timer_inc >= r_tail_to) begin
                        n_out       = mbrir_pkg::mk_status(mbrir_pkg::STAT_SHORT, 16'd0);
                        n_out_valid = 1'b1;
                        n_state     = mbrir_pkg::ST_IDLE;
                    end
                end else if (w_in_acc && i_req.func == mbrir_pkg::FUNC_BYTE) begin
                    if ({1'b0, r_idx} <= w_total_m3) begin
                        n_crc = mbrir_pkg::crc_add(r_crc, i_req.rx_byte);
                        if (r_idx == 8'd1 && i_req.rx_byte != mbrir_pkg::FUNC_CODE) begin
                            n_hdr_ok = 1'b0;
                        end
                        w_st_en = (r_idx >= 8'd3);
                        n_idx   = r_idx + 8'd1;
                    end else if ({1'b0, r_idx} == w_total_m3 + 9'd1) begin
                        n_crc_lo = i_req.rx_byte;
                        n_idx    = r_idx + 8'd1;
                    end else if ({i_req.rx_byte, r_crc_lo} != r_crc || !r_hdr_ok) begin
                        n_out       = mbrir_pkg::mk_status(mbrir_pkg::STAT_BAD, 16'd0);
                        n_out_valid = 1'b1;
                        n_state     = mbrir_pkg::ST_IDLE;
                    end else if (r_expected == 8'd0) begin
                        n_out       = mbrir_pkg::mk_status(mbrir_pkg::STAT_OK, r_latency);
                        n_out_valid = 1'b1;
                        n_state     = mbrir_pkg::ST_IDLE;
                    end else begin
                        n_word_idx = '0;
                        n_state    = mbrir_pkg::ST_EMIT_RD;
                    end
                end
            end
            mbrir_pkg::ST_EMIT_RD: begin
                n_state = mbrir_pkg::ST_EMIT_WR;
            end
            mbrir_pkg::ST_EMIT_WR: begin
                if (w_out_free) begin
                    n_out       = mbrir_pkg::mk_word(w_rd_data);
                    n_out_valid = 1'b1;
                    if (8'(r_word_idx) + 8'd1 == r_expected) begin
                        n_state = mbrir_pkg::ST_FIN;
                    end else begin
                        n_word_idx = r_word_idx + 1'b1;
                        n_state    = mbrir_pkg::ST_EMIT_RD;
                    end
                end
            end
            mbrir_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_out       = mbrir_pkg::mk_status(mbrir_pkg::STAT_OK, r_latency);
                    n_out_valid = 1'b1;
                    n_state     = mbrir_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mbrir_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbrir_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_target    <= 8'd0;
            r_expected  <= 8'd0;
            r_idx       <= 8'd0;
            r_tx_idx    <= 3'd0;
            r_crc       <= mbrir_pkg::CRC_INIT;
            r_hdr_ok    <= 1'b0;
            r_crc_lo    <= 8'd0;
            r_timer     <= 16'd0;
            r_latency   <= 16'd0;
            r_word_idx  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_target    <= n_target;
            r_expected  <= n_expected;
            r_idx       <= n_idx;
            r_tx_idx    <= n_tx_idx;
            r_crc       <= n_crc;
            r_hdr_ok    <= n_hdr_ok;
            r_crc_lo    <= n_crc_lo;
            r_timer     <= n_timer;
            r_latency   <= n_latency;
            r_word_idx  <= n_word_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_reg_addr <= n_reg_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp_to <= mbrir_pkg::RESP_TIMEOUT_RST;
            r_tail_to <= mbrir_pkg::TAIL_TIMEOUT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.reg_index == mbrir_pkg::CFG_RESP_TIMEOUT) begin
                r_resp_to <= i_cfg.wr_data;
            end
            if (i_cfg.reg_index == mbrir_pkg::CFG_TAIL_TIMEOUT) begin
                r_tail_to <= i_cfg.wr_data;
            end
        end
    end

endmodule

[src/mbrir_data_store.sv]
module mbrir_data_store #(
    parameter int MAX_REGS = mbrir_pkg::MAX_REGS_DEF,
    localparam int WAW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1
) (
    input  logic           i_clk,
    input  logic           i_byte_en,
    input  logic [WAW:0]   i_byte_pos,
    input  logic [7:0]     i_byte,
    input  logic [WAW-1:0] i_rd_addr,
    output logic [15:0]    o_rd_data
);

    logic [15:0] r_mem [MAX_REGS];
    logic [7:0]  r_hi_byte;
    logic [15:0] r_rd_data;

    // even position holds the high byte until its partner arrives
    always_ff @(posedge i_clk) begin
        if (i_byte_en && !i_byte_pos[0]) begin
            r_hi_byte <= i_byte;
        end
        if (i_byte_en && i_byte_pos[0]) begin
            r_mem[i_byte_pos[WAW:1]] <= {r_hi_byte, i_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/mbrir_checker.sv]
module mbrir_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_kind,
    input logic [1:0]  i_rsp_status,
    input logic [15:0] i_rsp_latency,
    input logic        i_rsp_last
);

    // pending word holds until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_kind)
            && $stable(i_rsp_status) && $stable(i_rsp_last))
        else $error("result word dropped or changed while stalled");

    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |-> !i_rsp_valid)
        else $error("input taken while a result is pending");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_last || i_rsp_kind == mbrir_pkg::KIND_STATUS)
            |-> i_rsp_last && i_rsp_kind == mbrir_pkg::KIND_STATUS)
        else $error("last and status kind disagree");

    a_lat_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != mbrir_pkg::STAT_OK |-> i_rsp_latency == 16'd0)
        else $error("latency on a failed run");

    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_ready && i_rsp_last |=> !i_rsp_valid)
        else $error("result after the end of a run");

endmodule

bind modbus_read_input_registers_master_top mbrir_checker u_mbrir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_kind    (o_rsp.kind),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_latency (o_rsp.latency_ticks),
    .i_rsp_last    (o_rsp.last)
);
